### design/uor_pkg.sv
// ----------------------------------------------------------------------------
// uor_pkg
// Shared types, constants and helper functions for the urgency-to-outstanding
// I/O ramp: segment edges, per-segment reciprocals and the budget split.
// ----------------------------------------------------------------------------
package uor_pkg;

    // Field widths and the top urgency level.
    localparam int LEVEL_W   = 7;
    localparam int BUDGET_W  = 16;
    localparam int LEVEL_MAX = 127;

    // Segment edges: the last level of each of the first three segments.
    localparam int EDGE1 = LEVEL_MAX / 8;
    localparam int EDGE2 = LEVEL_MAX / 4;
    localparam int EDGE3 = LEVEL_MAX / 2;

    // Segment lengths; the top segment is always the longest.
    localparam int LEN0 = EDGE1;
    localparam int LEN1 = EDGE2 - EDGE1;
    localparam int LEN2 = EDGE3 - EDGE2;
    localparam int LEN3 = LEVEL_MAX - EDGE3;

    // The ramp numerator is level offset times budget. Dividing it by a
    // segment length is a multiply by a rounded-up reciprocal and a shift.
    // With the shift at numerator width plus length width the quotient is
    // exact for every numerator. Budget times reciprocal is formed when the
    // ceiling is written, so an item only multiplies its offset by it.
    localparam int LEN_W     = $clog2(LEN3);
    localparam int PROD_W    = LEVEL_W + BUDGET_W;
    localparam int DIV_SHIFT = PROD_W + LEN_W;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int SCALE_W   = BUDGET_W + RECIP_W;
    localparam int WIDE_W    = LEVEL_W + SCALE_W;
    localparam int QUOT_W    = WIDE_W - DIV_SHIFT;

    localparam logic [RECIP_W-1:0] RECIP0 =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(LEN0) - 64'd1) / 64'(LEN0));
    localparam logic [RECIP_W-1:0] RECIP1 =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(LEN1) - 64'd1) / 64'(LEN1));
    localparam logic [RECIP_W-1:0] RECIP2 =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(LEN2) - 64'd1) / 64'(LEN2));
    localparam logic [RECIP_W-1:0] RECIP3 =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(LEN3) - 64'd1) / 64'(LEN3));

    // Ceiling after reset.
    localparam logic [BUDGET_W-1:0] CEILING_RESET = 16'd512;

    typedef logic [LEVEL_W-1:0]  level_t;
    typedef logic [BUDGET_W-1:0] budget_t;
    typedef logic [SCALE_W-1:0]  scale_t;
    typedef logic [QUOT_W-1:0]   quot_t;

    typedef enum logic [1:0] {
        SEG_LOW,
        SEG_MID,
        SEG_HIGH,
        SEG_TOP
    } segment_t;

    // Ceiling, per-segment budgets, the sum of the budgets below each one,
    // and each budget times its segment's reciprocal.
    typedef struct packed {
        budget_t             ceiling;
        logic [3:0][BUDGET_W-1:0] budget;
        logic [3:0][BUDGET_W-1:0] base;
        logic [3:0][SCALE_W-1:0]  scale;
    } budget_set_t;

    // Offset origin of a segment: 0 for the low one, else the last level before it.
    function automatic level_t seg_start(input segment_t seg);
        level_t r;
        case (seg)
            SEG_LOW:  r = '0;
            SEG_MID:  r = LEVEL_W'(EDGE1);
            SEG_HIGH: r = LEVEL_W'(EDGE2);
            SEG_TOP:  r = LEVEL_W'(EDGE3);
            default:  r = '0;
        endcase
        return r;
    endfunction

    // Split a ceiling into four budgets of at least one each.
    function automatic budget_set_t calc_budgets(input budget_t c);
        budget_set_t    r;
        budget_t        q32;
        budget_t        q4;
        budget_t        b1;
        budget_t        b2;
        budget_t        b3;
        budget_t        b4;
        logic [BUDGET_W:0] s12;
        logic [BUDGET_W:0] s123;
        b1 = c >> 7;
        if (b1 == '0)
        begin
            b1 = budget_t'(1);
        end
        q32 = c >> 5;
        b2  = (q32 > b1) ? (q32 - b1) : budget_t'(1);
        s12 = {1'b0, b1} + {1'b0, b2};
        q4  = c >> 2;
        b3  = ({1'b0, q4} > s12) ? (q4 - s12[BUDGET_W-1:0]) : budget_t'(1);
        s123 = s12 + {1'b0, b3};
        b4  = ({1'b0, c} > s123) ? (c - s123[BUDGET_W-1:0]) : budget_t'(1);
        r.ceiling   = c;
        r.budget[0] = b1;
        r.budget[1] = b2;
        r.budget[2] = b3;
        r.budget[3] = b4;
        r.base[0]   = '0;
        r.base[1]   = b1;
        r.base[2]   = s12[BUDGET_W-1:0];
        r.base[3]   = s123[BUDGET_W-1:0];
        // The reciprocals are constants, so these are shift-and-add products.
        r.scale[0]  = SCALE_W'(b1) * SCALE_W'(RECIP0);
        r.scale[1]  = SCALE_W'(b2) * SCALE_W'(RECIP1);
        r.scale[2]  = SCALE_W'(b3) * SCALE_W'(RECIP2);
        r.scale[3]  = SCALE_W'(b4) * SCALE_W'(RECIP3);
        return r;
    endfunction

endpackage

### design/uor_budget.sv
// ----------------------------------------------------------------------------
// uor_budget
// Ceiling register. Each write also stores the four budgets, their running
// bases and the scaled reciprocals so the datapath reads them from flops.
// ----------------------------------------------------------------------------
module uor_budget (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  uor_pkg::budget_t      cfg_wr_data,
    output uor_pkg::budget_set_t  budgets
);
    import uor_pkg::*;

    budget_set_t budget_set_reg;
    budget_set_t budget_set_next;

    // Split the written ceiling into budgets.
    always_comb
    begin
        budget_set_next = budget_set_reg;
        if (cfg_wr_en)
        begin
            budget_set_next = calc_budgets(cfg_wr_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_set_reg <= calc_budgets(CEILING_RESET);
        end
        else
        begin
            budget_set_reg <= budget_set_next;
        end
    end

    assign budgets = budget_set_reg;

endmodule

### design/uor_scale.sv
// ----------------------------------------------------------------------------
// uor_scale
// Input register, segment selection and the level's offset into its segment.
// ----------------------------------------------------------------------------
module uor_scale (
    input  logic                  clk,
    input  logic                  in_load,
    input  uor_pkg::level_t       urgent_level,
    output uor_pkg::segment_t     seg,
    output uor_pkg::level_t       rel
);
    import uor_pkg::*;

    level_t   level_reg;
    level_t   level_next;

    // Capture the level of each accepted beat.
    always_comb
    begin
        level_next = in_load ? urgent_level : level_reg;
    end

    // Find the segment and the offset into it.
    always_comb
    begin
        if (level_reg <= LEVEL_W'(EDGE1))
        begin
            seg = SEG_LOW;
        end
        else if (level_reg <= LEVEL_W'(EDGE2))
        begin
            seg = SEG_MID;
        end
        else if (level_reg <= LEVEL_W'(EDGE3))
        begin
            seg = SEG_HIGH;
        end
        else
        begin
            seg = SEG_TOP;
        end
        rel = level_reg - seg_start(seg);
    end

    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
    end

endmodule

### design/uor_divide.sv
// ----------------------------------------------------------------------------
// uor_divide
// Scales the level offset by the segment's budget and divides by the segment
// length, through one multiply by the stored budget-times-reciprocal and a
// fixed shift.
// ----------------------------------------------------------------------------
module uor_divide (
    input  uor_pkg::segment_t     seg,
    input  uor_pkg::level_t       rel,
    input  uor_pkg::budget_set_t  budgets,
    output uor_pkg::quot_t        quot
);
    import uor_pkg::*;

    logic [WIDE_W-1:0] wide;

    // The reciprocal is rounded up, so the upper bits are the exact quotient.
    always_comb
    begin
        wide = WIDE_W'(rel) * WIDE_W'(budgets.scale[seg]);
        quot = wide[WIDE_W-1:DIV_SHIFT];
    end

endmodule

### design/uor_finish.sv
// ----------------------------------------------------------------------------
// uor_finish
// Clamps the ramp to its budget, adds the lower budgets, clamps to the
// ceiling and holds the result in the output register.
// ----------------------------------------------------------------------------
module uor_finish (
    input  logic                  clk,
    input  logic                  out_load,
    input  uor_pkg::segment_t     seg,
    input  uor_pkg::quot_t        quot,
    input  uor_pkg::budget_set_t  budgets,
    output uor_pkg::budget_t      outstanding_limit
);
    import uor_pkg::*;

    budget_t           bud;
    budget_t           ramp;
    logic [BUDGET_W:0] total;
    budget_t           limit_reg;
    budget_t           limit_next;

    // Clamp to 1..budget, add the base, then clamp to 1..ceiling.
    always_comb
    begin
        bud = budgets.budget[seg];
        if (quot == '0)
        begin
            ramp = budget_t'(1);
        end
        else if (quot > QUOT_W'(bud))
        begin
            ramp = bud;
        end
        else
        begin
            ramp = quot[BUDGET_W-1:0];
        end
        total = {1'b0, ramp} + {1'b0, budgets.base[seg]};
        if (total > {1'b0, budgets.ceiling})
        begin
            limit_next = budgets.ceiling;
        end
        else
        begin
            limit_next = total[BUDGET_W-1:0];
        end
        if (limit_next == '0)
        begin
            limit_next = budget_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            limit_reg <= limit_next;
        end
    end

    assign outstanding_limit = limit_reg;

endmodule

### design/urgency_to_outstanding_io_ramp_core.sv
// ----------------------------------------------------------------------------
// urgency_to_outstanding_io_ramp_core
// Maps an urgency level to an allowed outstanding I/O count, ramping over
// four segments of the level range with budgets split from a ceiling.
// ----------------------------------------------------------------------------
//   Channel   Handshake                 Payload
//   item      item_valid / item_stall   urgent_level (7 bits)
//   result    result_valid/result_stall outstanding_limit (16 bits)
//   config    cfg_wr_en                 cfg_wr_data (16-bit ceiling)
//
// A beat waits in the input register while segment choice, one narrow
// multiply, a shift and the clamps run; the result register presents its
// limit. One beat is taken every cycle but while the input register holds,
// which it does only while the result register is full and stalled.
// Reset empties both registers and loads a ceiling of 512; no clearing pass.
// ----------------------------------------------------------------------------
module urgency_to_outstanding_io_ramp_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  uor_pkg::level_t   urgent_level,
    output logic              result_valid,
    input  logic              result_stall,
    output uor_pkg::budget_t  outstanding_limit,
    input  logic              cfg_wr_en,
    input  uor_pkg::budget_t  cfg_wr_data
);
    import uor_pkg::*;

    budget_set_t budgets;
    segment_t    seg;
    level_t      rel;
    quot_t       quot;
    logic        in_load;
    logic        out_load;

    logic in_valid_reg;
    logic in_valid_next;
    logic out_valid_reg;
    logic out_valid_next;

    // A register may load when it is empty or the one after it loads.
    always_comb
    begin
        out_load = !out_valid_reg || !result_stall;
        in_load  = !in_valid_reg  || out_load;
    end

    // Valid bits move with their data.
    always_comb
    begin
        in_valid_next  = in_load  ? item_valid   : in_valid_reg;
        out_valid_next = out_load ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign item_stall   = !in_load;
    assign result_valid = out_valid_reg;

    // Ceiling register and budget split.
    uor_budget u_budget (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .budgets     (budgets)
    );

    // Input register and segment selection.
    uor_scale u_scale (
        .clk          (clk),
        .in_load      (in_load),
        .urgent_level (urgent_level),
        .seg          (seg),
        .rel          (rel)
    );

    // Scaling and division by the segment length.
    uor_divide u_divide (
        .seg     (seg),
        .rel     (rel),
        .budgets (budgets),
        .quot    (quot)
    );

    // Clamping and output register.
    uor_finish u_finish (
        .clk               (clk),
        .out_load          (out_load),
        .seg               (seg),
        .quot              (quot),
        .budgets           (budgets),
        .outstanding_limit (outstanding_limit)
    );

endmodule

### dv/urgency_to_outstanding_io_ramp_core_tb.sv
// ----------------------------------------------------------------------------
// urgency_to_outstanding_io_ramp_core_tb
// Self-checking bench for the urgency ramp. Levels go in on the item channel
// in bursts with random gaps, and the result channel stalls in changing
// patterns. Each accepted level is turned into its expected outstanding
// limit by a local predictor under the current ceiling. Each limit that
// comes back is checked in order. The ceiling moves between phases while
// the pipeline is empty, from zero up to the full 16-bit range.
// ----------------------------------------------------------------------------
module urgency_to_outstanding_io_ramp_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Last level of each of the four segments.
    localparam int unsigned SEG_END_LOW  = uor_pkg::LEVEL_MAX / 8;
    localparam int unsigned SEG_END_MID  = uor_pkg::LEVEL_MAX / 4;
    localparam int unsigned SEG_END_HIGH = uor_pkg::LEVEL_MAX / 2;
    localparam int unsigned SEG_END_TOP  = uor_pkg::LEVEL_MAX;

    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned RANDOM_PHASES = 11;
    localparam int unsigned PHASE_LEVELS = 100;

    typedef struct {
        uor_pkg::level_t  level;
        uor_pkg::budget_t limit;
    } limit_expect_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_stall;
    uor_pkg::level_t   urgent_level = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    uor_pkg::budget_t  outstanding_limit;
    logic              cfg_wr_en = 1'b0;
    uor_pkg::budget_t  cfg_wr_data = '0;

    uor_pkg::level_t   level_backlog[$];
    limit_expect_t     expected_limits[$];
    int unsigned       ceiling_now = 512;

    int unsigned       mismatch_count = 0;
    int unsigned       levels_sent = 0;
    int unsigned       limits_checked = 0;
    int unsigned       ceilings_tried = 1;
    int unsigned       stall_cycles = 0;

    int unsigned       burst_left = 0;
    int unsigned       gap_left = 0;
    int unsigned       stall_mode = 0;
    int unsigned       mode_left = 0;
    int unsigned       hold_left = 0;
    int unsigned       idle_cycles = 0;

    urgency_to_outstanding_io_ramp_core dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item_stall        (item_stall),
        .urgent_level      (urgent_level),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .outstanding_limit (outstanding_limit),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data)
    );

    always #4 clk = ~clk;

    // Linear ramp of a level offset over one segment, held to 1..share.
    function automatic int unsigned ramp_share(input int unsigned offset,
                                               input int unsigned share,
                                               input int unsigned span);
        int unsigned v;
        v = (offset * share) / span;
        if (v < 1)
        begin
            v = 1;
        end
        if (v > share)
        begin
            v = share;
        end
        return v;
    endfunction

    // Outstanding limit for one level under a given ceiling.
    function automatic uor_pkg::budget_t predict_outstanding_limit(
        input int unsigned lvl,
        input int unsigned ceil_val
    );
        int unsigned share_low;
        int unsigned share_mid;
        int unsigned share_high;
        int unsigned share_top;
        int unsigned below_top;
        int unsigned lim;
        share_low = ceil_val / 128;
        if (share_low == 0)
        begin
            share_low = 1;
        end
        share_mid  = (ceil_val / 32 > share_low) ? ceil_val / 32 - share_low : 1;
        share_high = (ceil_val / 4 > share_low + share_mid) ?
                     ceil_val / 4 - (share_low + share_mid) : 1;
        below_top  = share_low + share_mid + share_high;
        share_top  = (ceil_val > below_top) ? ceil_val - below_top : 1;

        if (lvl <= SEG_END_LOW)
        begin
            lim = ramp_share(lvl, share_low, SEG_END_LOW);
        end
        else if (lvl <= SEG_END_MID)
        begin
            lim = ramp_share(lvl - SEG_END_LOW, share_mid, SEG_END_MID - SEG_END_LOW)
                  + share_low;
        end
        else if (lvl <= SEG_END_HIGH)
        begin
            lim = ramp_share(lvl - SEG_END_MID, share_high, SEG_END_HIGH - SEG_END_MID)
                  + share_low + share_mid;
        end
        else
        begin
            lim = ramp_share(lvl - SEG_END_HIGH, share_top, SEG_END_TOP - SEG_END_HIGH)
                  + below_top;
        end

        // A tiny ceiling caps the sum, and a zero ceiling still allows one.
        if (lim > ceil_val)
        begin
            lim = ceil_val;
        end
        if (lim < 1)
        begin
            lim = 1;
        end
        return uor_pkg::budget_t'(lim);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        mismatch_count++;
        if (mismatch_count <= 50)
        begin
            $display("[%0t] MISMATCH %s: expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // Wait until no level is queued, presented or still in flight.
    task automatic wait_drained();
        while (level_backlog.size() != 0 || item_valid || expected_limits.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_ceiling(input int unsigned value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= uor_pkg::budget_t'(value);
        ceiling_now = value & 16'hFFFF;
        ceilings_tried++;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Item driver: bursts of beats from the backlog with random gaps.
    always @(posedge clk or negedge rst_n)
    begin : level_driver
        logic taken;
        if (!rst_n)
        begin
            item_valid   <= 1'b0;
            urgent_level <= '0;
            burst_left   <= 0;
            gap_left     <= 0;
        end
        else
        begin
            taken = item_valid && !item_stall;
            if (taken)
            begin
                expected_limits.push_back(limit_expect_t'{urgent_level,
                    predict_outstanding_limit(urgent_level, ceiling_now)});
                levels_sent++;
            end
            if (taken || !item_valid)
            begin
                if (gap_left != 0 || level_backlog.size() == 0)
                begin
                    item_valid <= 1'b0;
                    if (gap_left != 0)
                    begin
                        gap_left <= gap_left - 1;
                    end
                end
                else
                begin
                    item_valid   <= 1'b1;
                    urgent_level <= level_backlog.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left <= ($urandom_range(0, 4) == 0) ?
                                      $urandom_range(40, 120) : $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 3) == 0) ?
                                      0 : $urandom_range(1, 5);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // Result stall: free-flowing, random, alternating or long holds.
    always @(posedge clk or negedge rst_n)
    begin : stall_pattern
        logic stall_next;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_mode   <= 0;
            mode_left    <= 0;
            hold_left    <= 0;
        end
        else
        begin
            stall_next = 1'b0;
            case (stall_mode)
                1: stall_next = ($urandom_range(0, 2) == 0);
                2: stall_next = !result_stall;
                3:
                begin
                    if (hold_left != 0)
                    begin
                        stall_next = 1'b1;
                        hold_left <= hold_left - 1;
                    end
                    else if ($urandom_range(0, 7) == 0)
                    begin
                        stall_next = 1'b1;
                        hold_left <= $urandom_range(4, 12);
                    end
                end
                default: stall_next = 1'b0;
            endcase
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(20, 80);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            result_stall <= stall_next;
            if (stall_next)
            begin
                stall_cycles++;
            end
        end
    end

    // Result monitor: each accepted beat against the oldest expectation.
    always @(posedge clk)
    begin : limit_monitor
        limit_expect_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_limits.size() == 0)
            begin
                report_mismatch("limit with no level outstanding", 0, outstanding_limit);
            end
            else
            begin
                want = expected_limits.pop_front();
                limits_checked++;
                if (outstanding_limit !== want.limit)
                begin
                    report_mismatch($sformatf("limit for level %0d, ceiling %0d",
                                              want.level, ceiling_now),
                                    want.limit, outstanding_limit);
                end
            end
        end
    end

    // Watchdog: too many cycles in a row with no beat on either channel.
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Stimulus: directed levels at a few ceilings, then random phases.
    initial
    begin : stimulus
        int unsigned edge_levels[15];
        int unsigned corner_levels[5];
        int unsigned fixed_ceilings[9];
        int unsigned cval;
        int unsigned pick;
        edge_levels    = '{0, 1, 2, 15, 16, 17, 31, 32, 33, 63, 64, 65, 100, 126, 127};
        corner_levels  = '{0, 15, 31, 63, 127};
        fixed_ceilings = '{4, 65535, 0, 1, 3, 127, 128, 4095, 32768};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Segment edges under the ceiling left by reset.
        foreach (edge_levels[i])
        begin
            level_backlog.push_back(uor_pkg::level_t'(edge_levels[i]));
        end
        wait_drained();

        // A ceiling too small for the budget split, then the full range.
        write_ceiling(2);
        foreach (corner_levels[i])
        begin
            level_backlog.push_back(uor_pkg::level_t'(corner_levels[i]));
        end
        wait_drained();
        write_ceiling(65535);
        foreach (corner_levels[i])
        begin
            level_backlog.push_back(uor_pkg::level_t'(corner_levels[i]));
        end
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase < 9)
            begin
                cval = fixed_ceilings[phase];
            end
            else
            begin
                cval = ($urandom_range(0, 1) == 0) ?
                       $urandom_range(0, 600) : $urandom_range(0, 65535);
            end
            write_ceiling(cval);
            repeat (PHASE_LEVELS)
            begin
                case ($urandom_range(0, 7))
                    0: pick = edge_levels[$urandom_range(0, 14)];
                    1: pick = ($urandom_range(0, 1) == 0) ? 0 : uor_pkg::LEVEL_MAX;
                    default: pick = $urandom_range(0, 127);
                endcase
                level_backlog.push_back(uor_pkg::level_t'(pick));
            end
            wait_drained();
        end

        // Let any stray result surface before the verdict.
        repeat (12) @(posedge clk);

        $display("Checked %0d limits from %0d levels over %0d ceiling settings.",
                 limits_checked, levels_sent, ceilings_tried);
        $display("Ceilings ran from 0 to 65535; the result side stalled on %0d cycles.",
                 stall_cycles);
        if (mismatch_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("%0d mismatches", mismatch_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
